@@ sv/brb_pkg.sv @@
`timescale 1ns / 1ps

package brb_pkg;

  // Field widths of the request and result channels
  localparam int CMD_W  = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 10;
  localparam int ST_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 3'd0,
    CMD_DEQ    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_SKIP   = 3'd3,
    CMD_COMMIT = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_STATUS = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_t;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_DATA  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_ADDR,
    S_RD_DATA
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // request taken this cycle
    logic rd_issue;  // read byte store at read cursor
    logic rd_emit;   // load result register with the byte read
    logic out_load;  // result register takes a new result
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic single;    // current request gives one immediate result
    logic run;       // current request starts a byte read run
    logic rd_last;   // byte at read cursor is the final one of the run
  } stat_t;

endpackage

@@ sv/brb_ram.sv @@
`timescale 1ns / 1ps

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

@@ sv/brb_ctrl.sv @@
`timescale 1ns / 1ps

module brb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  brb_pkg::stat_t stat,
  output brb_pkg::ctrl_t ctrl
);

  brb_pkg::state_t state;
  brb_pkg::state_t state_next;
  logic            out_valid_next;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      brb_pkg::S_IDLE: begin
        if (ctrl.accept && stat.run) begin
          state_next = brb_pkg::S_RD_ADDR;
        end
      end
      brb_pkg::S_RD_ADDR: begin
        state_next = brb_pkg::S_RD_DATA;
      end
      brb_pkg::S_RD_DATA: begin
        if (out_free) begin
          state_next = stat.rd_last ? brb_pkg::S_IDLE : brb_pkg::S_RD_ADDR;
        end
      end
      default: begin
        state_next = brb_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    ctrl.accept   = 1'b0;
    ctrl.rd_issue = 1'b0;
    ctrl.rd_emit  = 1'b0;
    case (state)
      brb_pkg::S_IDLE: begin
        in_stall    = !out_free;
        ctrl.accept = in_valid && out_free;
      end
      brb_pkg::S_RD_ADDR: begin
        ctrl.rd_issue = 1'b1;
      end
      brb_pkg::S_RD_DATA: begin
        ctrl.rd_emit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    ctrl.out_load = (ctrl.accept && stat.single) || ctrl.rd_emit;
  end

  // Hold a stalled result, drop it once taken
  assign out_valid_next = ctrl.out_load ? 1'b1 : (out_free ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brb_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ sv/brb_datapath.sv @@
`timescale 1ns / 1ps

module brb_datapath #(
  parameter int CAPACITY = 1023,
  parameter int MAX_READ = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [brb_pkg::CMD_W-1:0]    cmd,
  input  logic [brb_pkg::BYTE_W-1:0]   data_in,
  input  logic [brb_pkg::LEN_W-1:0]    length,
  input  logic                         burst_last,
  input  brb_pkg::ctrl_t               ctrl,
  output brb_pkg::stat_t               stat,
  output logic [brb_pkg::BYTE_W-1:0]   data_out,
  output logic [brb_pkg::ST_W-1:0]     status,
  output logic [brb_pkg::LEN_W-1:0]    done_count,
  output logic [brb_pkg::LEN_W-1:0]    used_count,
  output logic [brb_pkg::LEN_W-1:0]    free_count,
  output logic [brb_pkg::LEN_W-1:0]    direct_enqueue,
  output logic [brb_pkg::LEN_W-1:0]    direct_dequeue,
  output logic                         last
);

  localparam int SLOTS = CAPACITY + 1;
  localparam int PTR_W = $clog2(SLOTS);
  localparam int CW    = ((PTR_W > brb_pkg::LEN_W) ? PTR_W : brb_pkg::LEN_W) + 1;
  localparam int RD_W  = $clog2(MAX_READ + 1);

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                           input logic [CW-1:0] k);
    logic [CW-1:0] s;
    s = CW'(p) + k;
    if (s >= CW'(SLOTS)) begin
      s = s - CW'(SLOTS);
    end
    return s[PTR_W-1:0];
  endfunction

  logic [PTR_W-1:0] read_ptr;
  logic [PTR_W-1:0] write_ptr;
  logic             in_burst;
  logic             burst_accepted;
  logic [PTR_W-1:0] burst_count;

  logic [PTR_W-1:0] rd_cur;
  logic [RD_W-1:0]  rd_idx;
  logic [RD_W-1:0]  rd_n;
  logic             rd_deq;

  brb_pkg::cmd_t    op;
  logic [CW-1:0]    rp_w;
  logic [CW-1:0]    wp_w;
  logic [CW-1:0]    len_w;
  logic [CW-1:0]    used_w;
  logic [CW-1:0]    free_w;
  logic [CW-1:0]    n_w;
  logic [CW-1:0]    de_w;
  logic [CW-1:0]    dd_w;
  logic             enq_acc;
  logic             enq_wr;
  logic [PTR_W-1:0] cnt_new;
  logic [RD_W-1:0]  rd_idx_inc;
  logic [PTR_W-1:0] rd_cur_inc;
  logic [brb_pkg::BYTE_W-1:0] ram_q;

  logic [brb_pkg::ST_W-1:0] res_status;
  logic [CW-1:0]            res_done;
  logic [CW-1:0]            res_used;
  logic [CW-1:0]            res_free;
  logic [CW-1:0]            res_de;
  logic [CW-1:0]            res_dd;

  assign op    = brb_pkg::cmd_t'(cmd);
  assign rp_w  = CW'(read_ptr);
  assign wp_w  = CW'(write_ptr);
  assign len_w = CW'(length);

  assign used_w = (wp_w >= rp_w) ? (wp_w - rp_w) : (CW'(SLOTS) - rp_w + wp_w);
  assign free_w = CW'(CAPACITY) - used_w;
  assign n_w    = (len_w > CW'(MAX_READ)) ? CW'(MAX_READ) : len_w;
  assign de_w   = (wp_w < rp_w) ? (rp_w - wp_w - CW'(1))
                                : (CW'(CAPACITY) - wp_w + CW'(read_ptr != '0));
  assign dd_w   = (rp_w <= wp_w) ? (wp_w - rp_w) : (CW'(SLOTS) - rp_w);

  // Burst admission is decided on the first byte and kept for the rest
  assign enq_acc = in_burst ? burst_accepted : (len_w <= free_w);
  assign enq_wr  = enq_acc && (used_w < CW'(CAPACITY));
  assign cnt_new = (in_burst ? burst_count : '0) + PTR_W'(enq_wr);

  assign rd_idx_inc   = rd_idx + RD_W'(1);
  assign rd_cur_inc   = adv(rd_cur, CW'(1));

  always_comb begin
    stat.rd_last = (rd_idx_inc == rd_n);
    stat.single  = 1'b0;
    stat.run     = 1'b0;
    res_status   = brb_pkg::ST_OK;
    res_done     = '0;
    res_used     = '0;
    res_free     = '0;
    res_de       = '0;
    res_dd       = '0;
    case (op)
      brb_pkg::CMD_ENQ: begin
        stat.single = burst_last;
        res_status  = enq_acc ? brb_pkg::ST_OK : brb_pkg::ST_NO_SPACE;
        res_done    = enq_acc ? CW'(cnt_new) : '0;
      end
      brb_pkg::CMD_DEQ, brb_pkg::CMD_PEEK: begin
        if (used_w < n_w) begin
          stat.single = 1'b1;
          res_status  = brb_pkg::ST_NO_DATA;
        end else if (n_w == '0) begin
          stat.single = 1'b1;
        end else begin
          stat.run = 1'b1;
        end
      end
      brb_pkg::CMD_SKIP: begin
        stat.single = 1'b1;
        if (used_w < len_w) begin
          res_status = brb_pkg::ST_NO_DATA;
        end else begin
          res_done = len_w;
        end
      end
      brb_pkg::CMD_COMMIT: begin
        stat.single = 1'b1;
        if (free_w < len_w) begin
          res_status = brb_pkg::ST_NO_SPACE;
        end else begin
          res_done = len_w;
        end
      end
      brb_pkg::CMD_CLEAR: begin
        stat.single = 1'b1;
      end
      brb_pkg::CMD_STATUS: begin
        stat.single = 1'b1;
        res_used    = used_w;
        res_free    = free_w;
        res_de      = de_w;
        res_dd      = dd_w;
      end
      default: begin
        stat.single = 1'b0;
      end
    endcase
  end

  brb_ram #(
    .WIDTH(brb_pkg::BYTE_W),
    .DEPTH(SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (ctrl.accept && (op == brb_pkg::CMD_ENQ) && enq_wr),
    .waddr(write_ptr),
    .wdata(data_in),
    .re   (ctrl.rd_issue),
    .raddr(rd_cur),
    .q    (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr       <= '0;
      write_ptr      <= '0;
      in_burst       <= 1'b0;
      burst_accepted <= 1'b0;
      burst_count    <= '0;
    end else if (ctrl.accept) begin
      if (!(op inside {brb_pkg::CMD_NOP, brb_pkg::CMD_ENQ})) begin
        in_burst <= 1'b0;
      end
      case (op)
        brb_pkg::CMD_ENQ: begin
          in_burst       <= !burst_last;
          burst_accepted <= enq_acc;
          burst_count    <= cnt_new;
          if (enq_wr) begin
            write_ptr <= adv(write_ptr, CW'(1));
          end
        end
        brb_pkg::CMD_SKIP: begin
          if (used_w >= len_w) begin
            read_ptr <= adv(read_ptr, len_w);
          end
        end
        brb_pkg::CMD_COMMIT: begin
          if (free_w >= len_w) begin
            write_ptr <= adv(write_ptr, len_w);
          end
        end
        brb_pkg::CMD_CLEAR: begin
          read_ptr <= write_ptr;
        end
        default: begin
          read_ptr <= read_ptr;
        end
      endcase
    end else if (ctrl.rd_emit && stat.rd_last && rd_deq) begin
      read_ptr <= rd_cur_inc;
    end
  end

  // Read cursor for dequeue and peek runs
  always_ff @(posedge clk) begin
    if (ctrl.accept && stat.run) begin
      rd_cur <= read_ptr;
      rd_idx <= '0;
      rd_n   <= n_w[RD_W-1:0];
      rd_deq <= (op == brb_pkg::CMD_DEQ);
    end else if (ctrl.rd_emit) begin
      rd_cur <= rd_cur_inc;
      rd_idx <= rd_idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      if (ctrl.rd_emit) begin
        data_out       <= ram_q;
        status         <= brb_pkg::ST_OK;
        done_count     <= brb_pkg::LEN_W'(rd_n);
        used_count     <= '0;
        free_count     <= '0;
        direct_enqueue <= '0;
        direct_dequeue <= '0;
        last           <= stat.rd_last;
      end else begin
        data_out       <= '0;
        status         <= res_status;
        done_count     <= res_done[brb_pkg::LEN_W-1:0];
        used_count     <= res_used[brb_pkg::LEN_W-1:0];
        free_count     <= res_free[brb_pkg::LEN_W-1:0];
        direct_enqueue <= res_de[brb_pkg::LEN_W-1:0];
        direct_dequeue <= res_dd[brb_pkg::LEN_W-1:0];
        last           <= 1'b1;
      end
    end
  end

endmodule

@@ sv/byte_ring_buffer_unit.sv @@
`timescale 1ns / 1ps
// Enqueue bytes are taken one per cycle while the result register is free.
// Single-result requests are decided on the accept cycle; the result shows the next cycle.
// Dequeue and peek runs go through the accept cycle, then one address state and
// one data state per byte for the registered store read; the data state waits
// while a stalled result still holds the result register.
// Reset (rst, synchronous) empties the FIFO and drops any pending result; store not cleared.

module byte_ring_buffer_unit #(
  parameter int CAPACITY = 1023,  // bytes held at most; the store has one slot more
  parameter int MAX_READ = 64     // longest dequeue or peek run
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [brb_pkg::CMD_W-1:0]  cmd,
  input  logic [brb_pkg::BYTE_W-1:0] data_in,
  input  logic [brb_pkg::LEN_W-1:0]  length,
  input  logic                       burst_last,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [brb_pkg::BYTE_W-1:0] data_out,
  output logic [brb_pkg::ST_W-1:0]   status,
  output logic [brb_pkg::LEN_W-1:0]  done_count,
  output logic [brb_pkg::LEN_W-1:0]  used_count,
  output logic [brb_pkg::LEN_W-1:0]  free_count,
  output logic [brb_pkg::LEN_W-1:0]  direct_enqueue,
  output logic [brb_pkg::LEN_W-1:0]  direct_dequeue,
  output logic                       last
);

  // Controller decides when a request is taken and paces read runs;
  // the datapath owns pointers, burst state, the byte store and the
  // result register.
  brb_pkg::ctrl_t ctrl;
  brb_pkg::stat_t stat;

  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Decode of the request, size arithmetic and pointer moves all happen
  // in the datapath on the accept cycle; a read run then walks the store
  // with a private cursor and commits the front pointer on the final byte
  // of a dequeue.
  brb_datapath #(
    .CAPACITY(CAPACITY),
    .MAX_READ(MAX_READ)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .data_in       (data_in),
    .length        (length),
    .burst_last    (burst_last),
    .ctrl          (ctrl),
    .stat          (stat),
    .data_out      (data_out),
    .status        (status),
    .done_count    (done_count),
    .used_count    (used_count),
    .free_count    (free_count),
    .direct_enqueue(direct_enqueue),
    .direct_dequeue(direct_dequeue),
    .last          (last)
  );

endmodule

@@ sv/brb_checker.sv @@
`timescale 1ns / 1ps

module brb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [brb_pkg::BYTE_W-1:0] data_out,
  input logic [brb_pkg::ST_W-1:0]   status,
  input logic [brb_pkg::LEN_W-1:0]  done_count,
  input logic                       last
);

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(data_out) && $stable(status) &&
                               $stable(done_count) && $stable(last))
    else $error("stalled result changed");

  // A rejected request gives one final result that moved nothing
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != brb_pkg::ST_OK) |-> last && (done_count == '0))
    else $error("rejected request result malformed");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind byte_ring_buffer_unit brb_checker u_brb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .data_out  (data_out),
  .status    (status),
  .done_count(done_count),
  .last      (last)
);

@@ sim/byte_ring_buffer_unit_tb.sv @@
`timescale 1ns / 1ps

module byte_ring_buffer_unit_tb;

  localparam int CAP           = 1023;
  localparam int SLOTS         = CAP + 1;
  localparam int MAX_RD        = 64;
  localparam int RANDOM_TARGET = 460;      // requests before the stimulus stops
  localparam int HOLD_AT       = 150;      // start of the long receiver hold-off
  localparam int HOLD_CYCLES   = 200;
  localparam int QUIET_FROM    = 400;      // no idling on either side from here on
  localparam int DRAIN_CYCLES  = 32;
  localparam int CYCLE_LIMIT   = 2000000;

  // One result as it leaves the block, in port order
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] st;
    logic [9:0] done;
    logic [9:0] used;
    logic [9:0] free;
    logic [9:0] de;
    logic [9:0] dd;
    logic       fin;
  } reply_t;

  // Tracks the FIFO contents and pointers, and holds the replies still owed by the block
  class fifo_scoreboard;
    logic [7:0] bytes_held [SLOTS];
    bit         written [SLOTS];
    int         rd_idx;
    int         wr_idx;
    bit         in_burst;
    bit         burst_ok;
    int         burst_bytes;
    reply_t     pending_replies[$];
    int         errors;

    function new();
      for (int i = 0; i < SLOTS; i++) written[i] = 1'b0;
      rd_idx = 0;
      wr_idx = 0;
      in_burst = 1'b0;
      burst_ok = 1'b0;
      burst_bytes = 0;
      errors = 0;
    endfunction

    function int used_bytes();
      return (wr_idx >= rd_idx) ? wr_idx - rd_idx : SLOTS - rd_idx + wr_idx;
    endfunction

    function int free_bytes();
      return CAP - used_bytes();
    endfunction

    function int wrap_add(int p, int n);
      return (p + n >= SLOTS) ? p + n - SLOTS : p + n;
    endfunction

    // Bytes at the front that were really written, up to one read run
    function int filled_run();
      int k, p, held;
      held = used_bytes();
      k = 0;
      p = rd_idx;
      while (k < held && k < MAX_RD && written[p]) begin
        k++;
        p = wrap_add(p, 1);
      end
      return k;
    endfunction

    function void add_reply(logic [7:0] d, logic [1:0] st, int done,
                            int u, int f, int de, int dd, logic fin);
      pending_replies.push_back({d, st, 10'(done), 10'(u), 10'(f), 10'(de), 10'(dd), fin});
    endfunction

    // Advance the state by one accepted request and queue the replies it owes
    function void note_request(brb_pkg::cmd_t op, logic [7:0] din, logic [9:0] len,
                               logic blast);
      int held, n, p, de, dd, i;
      held = used_bytes();
      if (op == brb_pkg::CMD_NOP) return;
      if (op == brb_pkg::CMD_ENQ) begin
        if (!in_burst) begin
          in_burst = 1'b1;
          burst_ok = (len <= CAP - held);
          burst_bytes = 0;
        end
        if (burst_ok && held < CAP) begin
          bytes_held[wr_idx] = din;
          written[wr_idx] = 1'b1;
          wr_idx = wrap_add(wr_idx, 1);
          burst_bytes++;
        end
        if (blast) begin
          in_burst = 1'b0;
          if (burst_ok) add_reply(8'd0, brb_pkg::ST_OK, burst_bytes, 0, 0, 0, 0, 1'b1);
          else add_reply(8'd0, brb_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0, 1'b1);
        end
        return;
      end
      in_burst = 1'b0;
      case (op)
        brb_pkg::CMD_DEQ, brb_pkg::CMD_PEEK: begin
          n = (len > MAX_RD) ? MAX_RD : len;
          if (held < n) begin
            add_reply(8'd0, brb_pkg::ST_NO_DATA, 0, 0, 0, 0, 0, 1'b1);
          end else if (n == 0) begin
            add_reply(8'd0, brb_pkg::ST_OK, 0, 0, 0, 0, 0, 1'b1);
          end else begin
            p = rd_idx;
            for (i = 0; i < n; i++) begin
              add_reply(bytes_held[p], brb_pkg::ST_OK, n, 0, 0, 0, 0, i == n - 1);
              p = wrap_add(p, 1);
            end
            if (op == brb_pkg::CMD_DEQ) rd_idx = p;
          end
        end
        brb_pkg::CMD_SKIP: begin
          if (held < len) begin
            add_reply(8'd0, brb_pkg::ST_NO_DATA, 0, 0, 0, 0, 0, 1'b1);
          end else begin
            rd_idx = wrap_add(rd_idx, len);
            add_reply(8'd0, brb_pkg::ST_OK, len, 0, 0, 0, 0, 1'b1);
          end
        end
        brb_pkg::CMD_COMMIT: begin
          if (CAP - held < len) begin
            add_reply(8'd0, brb_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0, 1'b1);
          end else begin
            wr_idx = wrap_add(wr_idx, len);
            add_reply(8'd0, brb_pkg::ST_OK, len, 0, 0, 0, 0, 1'b1);
          end
        end
        brb_pkg::CMD_CLEAR: begin
          rd_idx = wr_idx;
          add_reply(8'd0, brb_pkg::ST_OK, 0, 0, 0, 0, 0, 1'b1);
        end
        default: begin
          de = (wr_idx < rd_idx) ? rd_idx - wr_idx - 1 : CAP - wr_idx + (rd_idx != 0);
          dd = (rd_idx <= wr_idx) ? wr_idx - rd_idx : SLOTS - rd_idx;
          add_reply(8'd0, brb_pkg::ST_OK, 0, held, CAP - held, de, dd, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [9:0] want, logic [9:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, data_out %0d status %0d done_count %0d last %0d",
                 $time, got.data, got.st, got.done, got.fin);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      compare_field("data_out", want.data, got.data);
      compare_field("status", want.st, got.st);
      compare_field("done_count", want.done, got.done);
      compare_field("used_count", want.used, got.used);
      compare_field("free_count", want.free, got.free);
      compare_field("direct_enqueue", want.de, got.de);
      compare_field("direct_dequeue", want.dd, got.dd);
      compare_field("last", want.fin, got.fin);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] cmd;
  logic [7:0] data_in;
  logic [9:0] length;
  logic       burst_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] data_out;
  logic [1:0] status;
  logic [9:0] done_count;
  logic [9:0] used_count;
  logic [9:0] free_count;
  logic [9:0] direct_enqueue;
  logic [9:0] direct_dequeue;
  logic       last;

  fifo_scoreboard sb;
  int             requests_sent;
  int             cycle_count;
  bit             quiet;      // set for the final stretch: no idling on either side
  bit             long_hold;  // raised by the stimulus, cleared by the receiver

  byte_ring_buffer_unit uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .data_in        (data_in),
    .length         (length),
    .burst_last     (burst_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_out       (data_out),
    .status         (status),
    .done_count     (done_count),
    .used_count     (used_count),
    .free_count     (free_count),
    .direct_enqueue (direct_enqueue),
    .direct_dequeue (direct_dequeue),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one request at the falling edge, hold it until the block takes it,
  // then let the scoreboard predict what it owes. Gaps open at random
  // before the request, never in response to the stall.
  task automatic issue_request(brb_pkg::cmd_t op, int din, int len, int blast);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    cmd        = op;
    data_in    = 8'(din);
    length     = 10'(len);
    burst_last = 1'(blast);
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, data_in, length, burst_last);
    if (op != brb_pkg::CMD_NOP) requests_sent++;
  endtask

  // Result side: random stall bursts, plus one long hold-off on request so
  // the result register backs up and the block stalls its input.
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Sample each accepted result at the rising edge, before the block updates it
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_reply({data_out, status, done_count, used_count, free_count,
                      direct_enqueue, direct_dequeue, last});
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int   pick, nbytes, flavor, declared, want, n, run, held, room, i;
    bit   hold_issued;
    brb_pkg::cmd_t op;

    sb            = new();
    requests_sent = 0;
    cycle_count   = 0;
    quiet         = 1'b0;
    long_hold     = 1'b0;
    hold_issued   = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = brb_pkg::CMD_NOP;
    data_in       = 8'd0;
    length        = 10'd0;
    burst_last    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty FIFO, zero-length requests, a small burst read back
    issue_request(brb_pkg::CMD_STATUS, 8'h00, 10'd0, 1'b0);
    issue_request(brb_pkg::CMD_DEQ, 8'hFF, 10'd1, 1'b1);
    issue_request(brb_pkg::CMD_PEEK, 8'h00, 10'd0, 1'b0);
    issue_request(brb_pkg::CMD_SKIP, 8'h00, 10'd0, 1'b0);
    issue_request(brb_pkg::CMD_COMMIT, 8'h00, 10'd0, 1'b0);
    issue_request(brb_pkg::CMD_ENQ, 8'h00, 10'd3, 1'b0);
    issue_request(brb_pkg::CMD_ENQ, 8'hFF, 10'd0, 1'b0);
    issue_request(brb_pkg::CMD_ENQ, 8'hA5, 10'h3FF, 1'b1);
    issue_request(brb_pkg::CMD_PEEK, 8'h00, 10'd3, 1'b0);
    issue_request(brb_pkg::CMD_DEQ, 8'h00, 10'd2, 1'b0);
    // Oversized read saturates to a run of 64, still more than held
    issue_request(brb_pkg::CMD_DEQ, 8'h00, 10'h3FF, 1'b0);
    issue_request(brb_pkg::CMD_SKIP, 8'h00, 10'd5, 1'b0);
    issue_request(brb_pkg::CMD_NOP, 8'hFF, 10'h3FF, 1'b1);
    // Burst declared larger than the room left: rejected as a whole
    issue_request(brb_pkg::CMD_ENQ, 8'h12, 10'h3FF, 1'b0);
    issue_request(brb_pkg::CMD_ENQ, 8'h34, 10'd0, 1'b1);
    // Burst cut short by another request: bytes stay, no burst result
    issue_request(brb_pkg::CMD_ENQ, 8'h55, 10'd2, 1'b0);
    issue_request(brb_pkg::CMD_ENQ, 8'hAA, 10'd0, 1'b0);
    issue_request(brb_pkg::CMD_STATUS, 8'h00, 10'd0, 1'b0);
    issue_request(brb_pkg::CMD_COMMIT, 8'h00, 10'h3FF, 1'b0);
    issue_request(brb_pkg::CMD_CLEAR, 8'h00, 10'd0, 1'b0);
    // Fill to the brim, then push a burst longer than declared into a full FIFO
    issue_request(brb_pkg::CMD_COMMIT, 8'h00, 10'h3FF, 1'b0);
    issue_request(brb_pkg::CMD_STATUS, 8'h00, 10'd0, 1'b0);
    issue_request(brb_pkg::CMD_ENQ, 8'h77, 10'd0, 1'b0);
    issue_request(brb_pkg::CMD_ENQ, 8'h88, 10'd5, 1'b1);
    issue_request(brb_pkg::CMD_SKIP, 8'h00, 10'h3FF, 1'b0);
    // Park both pointers near the top so the random part wraps early
    issue_request(brb_pkg::CMD_COMMIT, 8'h00, 10'd1000, 1'b0);
    issue_request(brb_pkg::CMD_SKIP, 8'h00, 10'd1000, 1'b0);

    // Random mix: mostly well-formed bursts and reads, with rejects and noise
    while (requests_sent < RANDOM_TARGET) begin
      if (requests_sent >= QUIET_FROM) quiet = 1'b1;
      if (!hold_issued && requests_sent >= HOLD_AT) begin
        long_hold   = 1'b1;
        hold_issued = 1'b1;
      end
      pick = $urandom_range(0, 99);
      held = sb.used_bytes();
      room = sb.free_bytes();
      if (pick < 40) begin
        // Declared length usually matches; sometimes random, shorter, or left open
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 16);
        flavor = $urandom_range(0, 9);
        declared = (flavor == 0) ? $urandom_range(0, 1023) :
                   (flavor == 1) ? $urandom_range(0, nbytes) : nbytes;
        for (i = 0; i < nbytes; i++)
          issue_request(brb_pkg::CMD_ENQ, $urandom_range(0, 255),
                        (i == 0) ? declared : $urandom_range(0, 1023),
                        flavor != 2 && i == nbytes - 1);
      end else if (pick < 70) begin
        op   = (pick < 55) ? brb_pkg::CMD_DEQ : brb_pkg::CMD_PEEK;
        want = ($urandom_range(0, 9) < 7) ? $urandom_range(0, held < MAX_RD ? held : MAX_RD)
                                          : $urandom_range(0, 1023);
        // Never read a slot that was only committed, not written
        n   = (want > MAX_RD) ? MAX_RD : want;
        run = sb.filled_run();
        if (n <= held && n > run) want = $urandom_range(0, run);
        issue_request(op, $urandom_range(0, 255), want, $urandom_range(0, 1));
      end else if (pick < 78) begin
        want = ($urandom_range(0, 9) < 7) ? $urandom_range(0, held) : $urandom_range(0, 1023);
        issue_request(brb_pkg::CMD_SKIP, $urandom_range(0, 255), want, $urandom_range(0, 1));
      end else if (pick < 86) begin
        want = ($urandom_range(0, 3) != 0) ? $urandom_range(0, room < 64 ? room : 64)
                                           : $urandom_range(0, 1023);
        issue_request(brb_pkg::CMD_COMMIT, $urandom_range(0, 255), want,
                      $urandom_range(0, 1));
      end else if (pick < 95) begin
        issue_request(brb_pkg::CMD_STATUS, $urandom_range(0, 255), $urandom_range(0, 1023),
                      $urandom_range(0, 1));
      end else if (pick < 97) begin
        issue_request(brb_pkg::CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1023),
                      $urandom_range(0, 1));
      end else begin
        issue_request(brb_pkg::CMD_NOP, $urandom_range(0, 255), $urandom_range(0, 1023),
                      $urandom_range(0, 1));
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    // Drain the owed results, then watch a little longer for strays
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
